@@ rtl/core/mbtrc_pkg.sv @@
// Shared types and constants for the Modbus TCP response checker.
package mbtrc_pkg;

  // Result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Frame and send status codes
  localparam logic [2:0] ST_READ_OK    = 3'd0;
  localparam logic [2:0] ST_WRITE_OK   = 3'd1;
  localparam logic [2:0] ST_EXCEPTION  = 3'd2;
  localparam logic [2:0] ST_MISMATCH   = 3'd3;
  localparam logic [2:0] ST_NO_REQUEST = 3'd4;
  localparam logic [2:0] ST_SHORT      = 3'd5;
  localparam logic [2:0] ST_SENT       = 3'd6;
  localparam logic [2:0] ST_BUSY       = 3'd7;

  // Input actions
  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  // MBAP framing constants
  localparam logic [15:0] MIN_LENGTH = 16'd3;
  localparam int          EXC_BIT    = 7;
  localparam logic [16:0] POS_TID_HI = 17'd0;
  localparam logic [16:0] POS_TID_LO = 17'd1;
  localparam logic [16:0] POS_LEN_HI = 17'd4;
  localparam logic [16:0] POS_LEN_LO = 17'd5;
  localparam logic [16:0] POS_UNIT   = 17'd6;
  localparam logic [16:0] POS_FUNC   = 17'd7;
  localparam logic [16:0] POS_COUNT  = 17'd8;
  localparam logic [16:0] POS_DATA   = 17'd9;
  localparam logic [16:0] POS_MAX    = 17'd65540;

  // Result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } result_t;

endpackage

@@ rtl/core/modbus_tcp_response_checker_core.sv @@
// Modbus TCP client response checker: MBAP deframer with request tracking.
//
// Input channel (in_valid / in_stall): each item is either a send action
// (in_action = 0), which claims the next transaction id when no request is
// outstanding, or one received stream byte (in_action = 1). Result channel
// (out_valid / out_stall) carries send acknowledgements, big-endian register
// words of a matching read reply, and one status item at the end of each
// frame; out_last marks the final result caused by an input item.
// cfg_we / cfg_wdata write the expected unit id; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Each input item is decoded in the cycle it is accepted and its results,
// zero to two of them, are registered into a four-entry result queue that
// feeds the output. One item is taken per cycle while in_stall is low.
// in_stall rises when the queue has fewer than two free entries, so
// a stalled receiver backs up into the input after two or three items that
// carry results.
// Reset (rst_n low, synchronous) empties the queue, clears the frame and
// request state, restarts transaction ids at zero and sets unit id to zero.
module modbus_tcp_response_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_request_is_read,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_word,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_last
);

  // Configuration and protocol state
  logic [7:0]  unit_id_r;
  logic [15:0] next_tid_r, next_tid_nxt;
  logic [15:0] exp_tid_r, exp_tid_nxt;
  logic        pending_r, pending_nxt;
  logic        pend_read_r, pend_read_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] rx_tid_r, rx_tid_nxt;
  logic        match_r, match_nxt;
  logic        exc_r, exc_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  high_r, high_nxt;
  logic        had_req_r, had_req_nxt;

  // Result queue
  mbtrc_pkg::result_t    queue_r [mbtrc_pkg::Q_DEPTH];
  logic [mbtrc_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [mbtrc_pkg::Q_CW-1:0] qcount_r, qcount_nxt;

  logic               in_acc, out_acc;
  logic [1:0]         push_n;
  mbtrc_pkg::result_t res0, res1;

  // Per-byte decode helpers
  logic [15:0] flen_eff;
  logic        match_eff, exc_eff, had_eff;
  logic [7:0]  count_eff;
  logic [16:0] data_idx;
  logic        emit_word, frame_end;
  logic [2:0]  st;
  logic [7:0]  code;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (qcount_r > mbtrc_pkg::Q_CW'(mbtrc_pkg::Q_DEPTH - 2));

  // Frame fields as they stand after this byte is applied
  always_comb begin
    flen_eff  = (pos_r == mbtrc_pkg::POS_LEN_LO) ? {flen_r[15:8], in_rx_byte} : flen_r;
    had_eff   = (pos_r == mbtrc_pkg::POS_LEN_LO) ? pending_r : had_req_r;
    match_eff = match_r;
    exc_eff   = exc_r;
    count_eff = count_r;
    case (pos_r)
      mbtrc_pkg::POS_LEN_LO: begin
        match_eff = pending_r && (rx_tid_r == exp_tid_r) &&
                    (flen_eff >= mbtrc_pkg::MIN_LENGTH);
        exc_eff   = 1'b0;
        count_eff = 8'd0;
      end
      mbtrc_pkg::POS_UNIT: begin
        if (in_rx_byte != unit_id_r) match_eff = 1'b0;
      end
      mbtrc_pkg::POS_FUNC: begin
        exc_eff = in_rx_byte[mbtrc_pkg::EXC_BIT];
      end
      mbtrc_pkg::POS_COUNT: begin
        count_eff = in_rx_byte;
      end
      default: begin
      end
    endcase
  end

  // Word emission, frame end and status selection
  always_comb begin
    data_idx  = pos_r - mbtrc_pkg::POS_DATA;
    emit_word = (pos_r >= mbtrc_pkg::POS_DATA) && data_idx[0] &&
                (data_idx < {9'd0, count_r}) && match_r && !exc_r && pend_read_r;
    frame_end = (pos_r >= mbtrc_pkg::POS_LEN_LO) &&
                (pos_r == 17'(mbtrc_pkg::POS_LEN_LO + {1'b0, flen_eff}));
    code = 8'd0;
    if (!had_eff) begin
      st = mbtrc_pkg::ST_NO_REQUEST;
    end else if (flen_eff < mbtrc_pkg::MIN_LENGTH) begin
      st = mbtrc_pkg::ST_SHORT;
    end else if (!match_eff) begin
      st = mbtrc_pkg::ST_MISMATCH;
    end else if (exc_eff) begin
      st   = mbtrc_pkg::ST_EXCEPTION;
      code = count_eff;
    end else begin
      st = pend_read_r ? mbtrc_pkg::ST_READ_OK : mbtrc_pkg::ST_WRITE_OK;
    end
  end

  // Next state and the results of the accepted item
  always_comb begin
    next_tid_nxt  = next_tid_r;
    exp_tid_nxt   = exp_tid_r;
    pending_nxt   = pending_r;
    pend_read_nxt = pend_read_r;
    pos_nxt       = pos_r;
    flen_nxt      = flen_r;
    rx_tid_nxt    = rx_tid_r;
    match_nxt     = match_r;
    exc_nxt       = exc_r;
    count_nxt     = count_r;
    high_nxt      = high_r;
    had_req_nxt   = had_req_r;
    push_n        = 2'd0;
    res0          = '0;
    res1          = '0;
    if (in_acc && (in_action == mbtrc_pkg::ACT_SEND)) begin
      push_n    = 2'd1;
      res0.kind = mbtrc_pkg::KIND_ACK;
      res0.last = 1'b1;
      if (pending_r) begin
        res0.status = mbtrc_pkg::ST_BUSY;
      end else begin
        exp_tid_nxt   = next_tid_r;
        next_tid_nxt  = next_tid_r + 16'd1;
        pending_nxt   = 1'b1;
        pend_read_nxt = in_request_is_read;
        res0.word     = next_tid_r;
        res0.status   = mbtrc_pkg::ST_SENT;
      end
    end else if (in_acc) begin
      // Header capture
      if (pos_r == mbtrc_pkg::POS_TID_HI) rx_tid_nxt = {in_rx_byte, 8'd0};
      if (pos_r == mbtrc_pkg::POS_TID_LO) rx_tid_nxt = {rx_tid_r[15:8], in_rx_byte};
      if (pos_r == mbtrc_pkg::POS_LEN_HI) flen_nxt = {in_rx_byte, 8'd0};
      if (pos_r == mbtrc_pkg::POS_LEN_LO) flen_nxt = flen_eff;
      match_nxt   = match_eff;
      exc_nxt     = exc_eff;
      count_nxt   = count_eff;
      had_req_nxt = had_eff;
      if ((pos_r >= mbtrc_pkg::POS_DATA) && !data_idx[0]) high_nxt = in_rx_byte;
      // Register word result
      if (emit_word) begin
        res0.kind = mbtrc_pkg::KIND_WORD;
        res0.word = {high_r, in_rx_byte};
        res0.last = !frame_end;
      end
      // Frame status result and frame restart
      if (frame_end) begin
        if ((st == mbtrc_pkg::ST_EXCEPTION) || (st == mbtrc_pkg::ST_READ_OK) ||
            (st == mbtrc_pkg::ST_WRITE_OK)) begin
          pending_nxt = 1'b0;
        end
        res1.kind           = mbtrc_pkg::KIND_STATUS;
        res1.status         = st;
        res1.exception_code = code;
        res1.last           = 1'b1;
        pos_nxt     = '0;
        match_nxt   = 1'b0;
        exc_nxt     = 1'b0;
        had_req_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 17'd1;
      end
      // Pack results into the first free slots
      if (emit_word && frame_end) begin
        push_n = 2'd2;
      end else if (emit_word) begin
        push_n = 2'd1;
      end else if (frame_end) begin
        push_n = 2'd1;
        res0   = res1;
      end
    end
  end

  // Protocol state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r   <= 8'd0;
      next_tid_r  <= 16'd0;
      exp_tid_r   <= 16'd0;
      pending_r   <= 1'b0;
      pend_read_r <= 1'b0;
      pos_r       <= 17'd0;
      flen_r      <= 16'd0;
      rx_tid_r    <= 16'd0;
      match_r     <= 1'b0;
      exc_r       <= 1'b0;
      count_r     <= 8'd0;
      high_r      <= 8'd0;
      had_req_r   <= 1'b0;
    end else begin
      if (cfg_we) unit_id_r <= cfg_wdata;
      next_tid_r  <= next_tid_nxt;
      exp_tid_r   <= exp_tid_nxt;
      pending_r   <= pending_nxt;
      pend_read_r <= pend_read_nxt;
      pos_r       <= pos_nxt;
      flen_r      <= flen_nxt;
      rx_tid_r    <= rx_tid_nxt;
      match_r     <= match_nxt;
      exc_r       <= exc_nxt;
      count_r     <= count_nxt;
      high_r      <= high_nxt;
      had_req_r   <= had_req_nxt;
    end
  end

  // Result queue occupancy
  always_comb begin
    qcount_nxt = qcount_r + mbtrc_pkg::Q_CW'(push_n) - mbtrc_pkg::Q_CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcount_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + mbtrc_pkg::Q_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + mbtrc_pkg::Q_AW'(out_acc);
      qcount_r <= qcount_nxt;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue_r[wr_ptr_r] <= res0;
    if (push_n == 2'd2) queue_r[wr_ptr_r + mbtrc_pkg::Q_AW'(1)] <= res1;
  end

  // Output side reads the queue head
  assign out_valid          = (qcount_r != '0);
  assign out_kind           = queue_r[rd_ptr_r].kind;
  assign out_word           = queue_r[rd_ptr_r].word;
  assign out_status         = queue_r[rd_ptr_r].status;
  assign out_exception_code = queue_r[rd_ptr_r].exception_code;
  assign out_last           = queue_r[rd_ptr_r].last;

  // The queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= mbtrc_pkg::Q_CW'(mbtrc_pkg::Q_DEPTH))
    else $error("result queue overflow");

  // A send always leaves a request outstanding.
  a_send_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == mbtrc_pkg::ACT_SEND)) |=> pending_r)
    else $error("send did not leave a request pending");

  // A granted send advances the transaction counter by one.
  a_tid_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == mbtrc_pkg::ACT_SEND) && !pending_r) |=>
    (next_tid_r == $past(next_tid_r) + 16'd1) && (exp_tid_r == $past(next_tid_r)))
    else $error("transaction id did not advance");

  // The byte position never runs past the longest possible frame.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mbtrc_pkg::POS_MAX)
    else $error("byte position beyond frame bound");

endmodule
